/* hw/rtl/dmx_widget_frame_parser_assert.svh */
// Assertion macros shared by the DMX widget frame parser modules.
`ifndef DMX_WIDGET_FRAME_PARSER_ASSERT_SVH
`define DMX_WIDGET_FRAME_PARSER_ASSERT_SVH

// The antecedent implies the consequent in the same cycle.
`define DWFP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dmx frame parser: same-cycle check failed");

// The antecedent implies the consequent in the next cycle.
`define DWFP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dmx frame parser: next-cycle check failed");

`endif

/* hw/rtl/dwfp_pkg.sv */
// Shared types and constants of the DMX widget frame parser.
package dwfp_pkg;

  // Framing bytes and widget labels.
  localparam logic [7:0] FRAME_SOM  = 8'h7E;
  localparam logic [7:0] FRAME_EOM  = 8'hE7;
  localparam logic [7:0] LBL_PARAMS = 8'd3;
  localparam logic [7:0] LBL_SERIAL = 8'd10;
  localparam logic [7:0] LBL_DMX_U0 = 8'd6;
  localparam logic [7:0] LBL_RX_ON  = 8'd8;

  // Field widths of one result.
  localparam int unsigned CHAN_W = 10;
  localparam int unsigned KIND_W = 3;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_FW_VERSION = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SERIAL     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BREAK      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAB        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_U2_LABEL   = 3'd5;

  // Depth of the command queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);

  // Result kinds as seen on the output.
  typedef enum logic [KIND_W-1:0] {
    KIND_NONE   = 3'd0,
    KIND_CHAN   = 3'd1,
    KIND_COMMIT = 3'd2,
    KIND_ABORT  = 3'd3,
    KIND_REPLY  = 3'd4
  } kind_e;

  // What the back end does with a queued command.
  typedef enum logic [1:0] {
    CMD_SINGLE = 2'd0,
    CMD_PARAMS = 2'd1,
    CMD_SERIAL = 2'd2
  } cmd_op_e;

  // One classified input byte.
  typedef struct packed {
    cmd_op_e           op;
    logic              consumed;
    kind_e             kind;
    logic              universe;
    logic [CHAN_W-1:0] chan_idx;
    logic [7:0]        value;
    logic [CHAN_W-1:0] chan_cnt;
    logic              stream_en;
  } cmd_t;

  // Configuration register file contents.
  typedef struct packed {
    logic [15:0] fw_version;
    logic [31:0] serial;
    logic [7:0]  break_time;
    logic [7:0]  mab_time;
    logic [7:0]  output_rate;
    logic [7:0]  u2_label;
  } cfg_regs_t;

endpackage

/* hw/rtl/dmx_widget_frame_parser.sv */
// Top level of the DMX widget frame parser: config registers, front end, queue, back end.
//
//   channel   direction  handshake                    payload
//   input     in         in_valid_i / in_stall_o      rx_byte_i
//   output    out        out_valid_o / out_stall_i    consumed_o .. last_o
//   config    in         cfg_we_i                     cfg_index_i, cfg_wdata_i
//
// One host byte is accepted per cycle while in_stall_o is low and yields one result;
// results leave one per cycle while out_stall_i is low. A parameters or serial request
// yields a framed reply of 10 or 9 results, and a four-entry command queue absorbs the
// bytes that arrive meanwhile. in_stall_o is high only while that queue is full; the output
// register lets a new byte enter while a finished result still waits on out_stall_i.
// Reset clears the parser, the queue and the output valid, and loads register defaults.
module dmx_widget_frame_parser import dwfp_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = 600
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            rx_byte_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  consumed_o,
  output logic [KIND_W-1:0]     kind_o,
  output logic                  universe_o,
  output logic [CHAN_W-1:0]     channel_index_o,
  output logic [7:0]            value_o,
  output logic [CHAN_W-1:0]     channel_count_o,
  output logic                  stream_enabled_o,
  output logic                  last_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  cfg_regs_t cfg_q, cfg_d;
  logic      push, pop, q_full, q_empty;
  cmd_t      push_cmd, head_cmd;

  // Configuration register writes.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_FW_VERSION: cfg_d.fw_version  = cfg_wdata_i[15:0];
        CFG_SERIAL:     cfg_d.serial      = cfg_wdata_i;
        CFG_BREAK:      cfg_d.break_time  = cfg_wdata_i[7:0];
        CFG_MAB:        cfg_d.mab_time    = cfg_wdata_i[7:0];
        CFG_RATE:       cfg_d.output_rate = cfg_wdata_i[7:0];
        CFG_U2_LABEL:   cfg_d.u2_label    = cfg_wdata_i[7:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fw_version  <= 16'd324;
      cfg_q.serial      <= 32'd57;
      cfg_q.break_time  <= 8'd9;
      cfg_q.mab_time    <= 8'd1;
      cfg_q.output_rate <= 8'd0;
      cfg_q.u2_label    <= 8'd202;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  dwfp_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .rx_byte_i  (rx_byte_i),
    .q_full_i   (q_full),
    .u2_label_i (cfg_q.u2_label),
    .in_stall_o (in_stall_o),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  dwfp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .pop_i   (pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .head_o  (head_cmd)
  );

  dwfp_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_i           (head_cmd),
    .empty_i          (q_empty),
    .cfg_i            (cfg_q),
    .out_stall_i      (out_stall_i),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .consumed_o       (consumed_o),
    .kind_o           (kind_o),
    .universe_o       (universe_o),
    .channel_index_o  (channel_index_o),
    .value_o          (value_o),
    .channel_count_o  (channel_count_o),
    .stream_enabled_o (stream_enabled_o),
    .last_o           (last_o)
  );

endmodule

/* hw/rtl/dwfp_front.sv */
// Front end: deframes host bytes and turns each one into a queued command.
module dwfp_front import dwfp_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = 600
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [7:0] rx_byte_i,
  input  logic       q_full_i,
  input  logic [7:0] u2_label_i,
  output logic       in_stall_o,
  output logic       push_o,
  output cmd_t       cmd_o
);

  localparam int unsigned PosW = $clog2(MAX_PAYLOAD + 1);
  localparam logic [15:0] MaxLen = 16'(MAX_PAYLOAD);

  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_LABEL = 3'd1,
    PH_LENLO = 3'd2,
    PH_LENHI = 3'd3,
    PH_DATA  = 3'd4,
    PH_END   = 3'd5
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [7:0]      label_q, label_d;
  logic [7:0]      len_lo_q, len_lo_d;
  logic [PosW-1:0] len_q, len_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic            flag_q, flag_d;

  logic            accept;
  logic [15:0]     len_full;
  logic [PosW-1:0] pos_inc;
  logic            is_dmx;
  logic            uni;
  cmd_t            cmd;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign push_o     = accept;
  assign cmd_o      = cmd;

  assign len_full = {rx_byte_i, len_lo_q};
  assign pos_inc  = pos_q + PosW'(1);

  // Label classification; parameters and serial labels win over DMX labels.
  assign is_dmx = (label_q != LBL_PARAMS) && (label_q != LBL_SERIAL) &&
                  ((label_q == LBL_DMX_U0) || (label_q == u2_label_i));
  assign uni    = (label_q == LBL_DMX_U0) ? 1'b0 : 1'b1;

  // Next state and the command for the byte at the input.
  always_comb begin
    phase_d  = phase_q;
    label_d  = label_q;
    len_lo_d = len_lo_q;
    len_d    = len_q;
    pos_d    = pos_q;
    flag_d   = flag_q;
    cmd          = '0;
    cmd.op       = CMD_SINGLE;
    cmd.consumed = 1'b1;
    cmd.kind     = KIND_NONE;
    case (phase_q)
      PH_LABEL: begin
        label_d = rx_byte_i;
        phase_d = PH_LENLO;
      end
      PH_LENLO: begin
        len_lo_d = rx_byte_i;
        phase_d  = PH_LENHI;
      end
      PH_LENHI: begin
        pos_d = '0;
        if (len_full == 16'd0) begin
          len_d   = '0;
          phase_d = PH_END;
        end else if (len_full <= MaxLen) begin
          len_d   = PosW'(len_full);
          phase_d = PH_DATA;
        end else begin
          phase_d = PH_START;
        end
      end
      PH_DATA: begin
        // The first payload byte is the DMX start code and is not streamed.
        if (is_dmx && (pos_q != '0)) begin
          cmd.kind     = KIND_CHAN;
          cmd.universe = uni;
          cmd.chan_idx = CHAN_W'(pos_q - PosW'(1));
          cmd.value    = rx_byte_i;
        end
        pos_d = pos_inc;
        if (pos_inc >= len_q) begin
          phase_d = PH_END;
        end
      end
      PH_END: begin
        phase_d = PH_START;
        if (rx_byte_i == FRAME_EOM) begin
          if (label_q == LBL_PARAMS) begin
            cmd.op   = CMD_PARAMS;
            cmd.kind = KIND_REPLY;
          end else if (label_q == LBL_SERIAL) begin
            cmd.op   = CMD_SERIAL;
            cmd.kind = KIND_REPLY;
          end else if (is_dmx) begin
            if (len_q != '0) begin
              cmd.kind     = KIND_COMMIT;
              cmd.universe = uni;
              cmd.chan_cnt = CHAN_W'(len_q - PosW'(1));
            end
          end else if (label_q == LBL_RX_ON) begin
            flag_d = 1'b1;
          end
        end else if (is_dmx && (len_q != '0)) begin
          cmd.kind     = KIND_ABORT;
          cmd.universe = uni;
        end
      end
      default: begin
        // Waiting for a start byte; anything else is not ours.
        phase_d = PH_START;
        if (rx_byte_i == FRAME_SOM) begin
          phase_d = PH_LABEL;
        end else begin
          cmd.consumed = 1'b0;
        end
      end
    endcase
    cmd.stream_en = flag_d;
  end

  // Parser state advances on every accepted byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_START;
      label_q  <= '0;
      len_lo_q <= '0;
      len_q    <= '0;
      pos_q    <= '0;
      flag_q   <= 1'b0;
    end else if (accept) begin
      phase_q  <= phase_d;
      label_q  <= label_d;
      len_lo_q <= len_lo_d;
      len_q    <= len_d;
      pos_q    <= pos_d;
      flag_q   <= flag_d;
    end
  end

endmodule

/* hw/rtl/dwfp_queue.sv */
// Command queue that decouples the front end from the result emitter.
`include "dmx_widget_frame_parser_assert.svh"

module dwfp_queue import dwfp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  input  logic pop_i,
  output logic full_o,
  output logic empty_o,
  output cmd_t head_o
);

  cmd_t              entries_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   count_q;

  assign full_o  = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = entries_q[rd_ptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + (QPTR_W + 1)'(1);
        2'b01:   count_q <= count_q - (QPTR_W + 1)'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= data_i;
    end
  end

  `DWFP_ASSERT_IMP(a_no_push_when_full, push_i, !full_o)
  `DWFP_ASSERT_IMP(a_no_pop_when_empty, pop_i, !empty_o)
  `DWFP_ASSERT_IMP(a_empty_ptrs_meet, empty_o, wr_ptr_q == rd_ptr_q)

endmodule

/* hw/rtl/dwfp_back.sv */
// Back end: expands queued commands into results and holds the output register.
`include "dmx_widget_frame_parser_assert.svh"

module dwfp_back import dwfp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              head_i,
  input  logic              empty_i,
  input  cfg_regs_t         cfg_i,
  input  logic              out_stall_i,
  output logic              pop_o,
  output logic              out_valid_o,
  output logic              consumed_o,
  output logic [KIND_W-1:0] kind_o,
  output logic              universe_o,
  output logic [CHAN_W-1:0] channel_index_o,
  output logic [7:0]        value_o,
  output logic [CHAN_W-1:0] channel_count_o,
  output logic              stream_enabled_o,
  output logic              last_o
);

  // Beat positions within a framed reply.
  localparam logic [3:0] BEAT_START  = 4'd0;
  localparam logic [3:0] BEAT_LABEL  = 4'd1;
  localparam logic [3:0] BEAT_LEN_LO = 4'd2;
  localparam logic [3:0] BEAT_LEN_HI = 4'd3;
  localparam logic [3:0] BEAT_BODY   = 4'd4;
  localparam logic [7:0] PARAMS_BODY_LEN = 8'd5;
  localparam logic [7:0] SERIAL_BODY_LEN = 8'd4;
  localparam logic [3:0] PARAMS_LAST_BEAT = BEAT_BODY + 4'(PARAMS_BODY_LEN);
  localparam logic [3:0] SERIAL_LAST_BEAT = BEAT_BODY + 4'(SERIAL_BODY_LEN);

  logic [3:0] beat_q, beat_d;
  logic       out_valid_q, out_valid_d;
  logic       load, take, final_beat;
  logic [3:0] last_beat;
  logic [2:0] body_idx;
  logic [7:0] body_byte, reply_byte;
  logic       is_params;

  logic              consumed_q;
  logic [KIND_W-1:0] kind_q;
  logic              universe_q;
  logic [CHAN_W-1:0] chan_idx_q;
  logic [7:0]        value_q;
  logic [CHAN_W-1:0] chan_cnt_q;
  logic              stream_en_q;
  logic              last_q;

  assign is_params  = (head_i.op == CMD_PARAMS);
  assign last_beat  = is_params ? PARAMS_LAST_BEAT : SERIAL_LAST_BEAT;
  assign final_beat = (head_i.op == CMD_SINGLE) || (beat_q == last_beat);
  assign load       = !out_valid_q || !out_stall_i;
  assign take       = load && !empty_i;
  assign pop_o      = take && final_beat;
  assign body_idx   = 3'(beat_q - BEAT_BODY);

  // Reply body byte for the current beat.
  always_comb begin
    body_byte = '0;
    if (is_params) begin
      case (body_idx)
        3'd0:    body_byte = cfg_i.fw_version[7:0];
        3'd1:    body_byte = cfg_i.fw_version[15:8];
        3'd2:    body_byte = cfg_i.break_time;
        3'd3:    body_byte = cfg_i.mab_time;
        3'd4:    body_byte = cfg_i.output_rate;
        default: body_byte = '0;
      endcase
    end else begin
      case (body_idx)
        3'd0:    body_byte = cfg_i.serial[7:0];
        3'd1:    body_byte = cfg_i.serial[15:8];
        3'd2:    body_byte = cfg_i.serial[23:16];
        3'd3:    body_byte = cfg_i.serial[31:24];
        default: body_byte = '0;
      endcase
    end
  end

  // Framed reply byte: start, label, length, body, end.
  always_comb begin
    if (beat_q == BEAT_START) begin
      reply_byte = FRAME_SOM;
    end else if (beat_q == BEAT_LABEL) begin
      reply_byte = is_params ? LBL_PARAMS : LBL_SERIAL;
    end else if (beat_q == BEAT_LEN_LO) begin
      reply_byte = is_params ? PARAMS_BODY_LEN : SERIAL_BODY_LEN;
    end else if (beat_q == BEAT_LEN_HI) begin
      reply_byte = '0;
    end else if (beat_q == last_beat) begin
      reply_byte = FRAME_EOM;
    end else begin
      reply_byte = body_byte;
    end
  end

  // Beat counter and output valid.
  always_comb begin
    beat_d      = beat_q;
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = take;
    end
    if (take) begin
      beat_d = final_beat ? '0 : beat_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      beat_q      <= beat_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload register, loaded with each emitted transaction.
  always_ff @(posedge clk_i) begin
    if (take) begin
      consumed_q  <= head_i.consumed;
      kind_q      <= head_i.kind;
      universe_q  <= head_i.universe;
      chan_idx_q  <= head_i.chan_idx;
      value_q     <= (head_i.op == CMD_SINGLE) ? head_i.value : reply_byte;
      chan_cnt_q  <= head_i.chan_cnt;
      stream_en_q <= head_i.stream_en;
      last_q      <= final_beat;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign consumed_o       = consumed_q;
  assign kind_o           = kind_q;
  assign universe_o       = universe_q;
  assign channel_index_o  = chan_idx_q;
  assign value_o          = value_q;
  assign channel_count_o  = chan_cnt_q;
  assign stream_enabled_o = stream_en_q;
  assign last_o           = last_q;

  `DWFP_ASSERT_IMP(a_reply_keeps_head, beat_q != 4'd0, !empty_i && (head_i.op != CMD_SINGLE))
  `DWFP_ASSERT_IMP(a_beat_in_range, 1'b1, beat_q <= PARAMS_LAST_BEAT)
  `DWFP_ASSERT_NXT(a_pop_marks_last, pop_o, out_valid_q && last_q)

endmodule
